// File: hw/rtl/grn_pkg.sv
package grn_pkg;

   localparam int CoordW = 12;

   localparam logic [1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [1:0] CSR_GRID_W    = 2'd1;
   localparam logic [1:0] CSR_GRID_H    = 2'd2;

   localparam logic [10:0] GRID_LIMIT = 11'd1024;

   typedef struct packed {
      logic [9:0]  center_x;
      logic [9:0]  center_y;
      logic [15:0] radius;
   } req_type;

   typedef struct packed {
      logic [9:0] cell_x;
      logic [9:0] cell_y;
      logic [1:0] ring;
      logic       radius_clamped;
      logic       last;
   } rsp_type;

   // one candidate cell from the ring walker
   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [1:0]        ring;
      logic              in_grid;
   } cand_type;

   typedef struct packed {
      logic [1:0] rings;
      logic       clamped;
   } div_res_type;

endpackage

// File: hw/rtl/grn_div.sv
module grn_div #(
   parameter int MAX_RING = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [17:0]               numer,
   input  logic [10:0]               denom,
   input  logic                      zero_div,
   output logic                      done,
   output grn_pkg::div_res_type      res
);

   localparam logic [1:0] MaxRing = 2'(MAX_RING);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [17:0]          rem_ff, rem_in;
   logic [1:0]           cnt_ff, cnt_in;
   grn_pkg::div_res_type res_ff, res_in;
   logic                 fits;
   logic                 at_max;

   // repeated subtract, stopping once the quotient reaches the ring limit
   always_comb begin
      fits    = rem_ff >= {7'd0, denom};
      at_max  = cnt_ff == MaxRing;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = numer;
         cnt_in  = 2'd0;
      end else if (busy_ff) begin
         if (zero_div) begin
            busy_in        = 1'b0;
            done_in        = 1'b1;
            res_in.rings   = MaxRing;
            res_in.clamped = 1'b1;
         end else if (fits && !at_max) begin
            rem_in = rem_ff - {7'd0, denom};
            cnt_in = cnt_ff + 2'd1;
         end else begin
            busy_in        = 1'b0;
            done_in        = 1'b1;
            res_in.clamped = at_max;
            res_in.rings   = at_max ? MaxRing : cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// File: hw/rtl/grn_walk.sv
module grn_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  advance,
   input  logic [9:0]            cx,
   input  logic [9:0]            cy,
   input  logic [1:0]            rings,
   input  logic [10:0]           grid_w,
   input  logic [10:0]           grid_h,
   output logic                  active,
   output grn_pkg::cand_type     cand
);

   localparam int CW = grn_pkg::CoordW;

   typedef enum logic [1:0] {
      SIDE_RIGHT,
      SIDE_LEFT,
      SIDE_TOP,
      SIDE_BOTTOM
   } side_type;

   logic               active_ff, active_in;
   logic [1:0]         ring_ff, ring_in;
   side_type           side_ff, side_in;
   logic signed [3:0]  idx_ff, idx_in;
   logic signed [3:0]  ring_s;
   logic signed [3:0]  hi;
   logic [CW-1:0]      cxs, cys, rs, is;
   logic [CW-1:0]      x, y;

   always_comb begin
      ring_s = signed'({2'b00, ring_ff});
      if (side_ff == SIDE_RIGHT || side_ff == SIDE_LEFT) begin
         hi = ring_s;
      end else begin
         hi = ring_s - 4'sd1;
      end

      cxs = {2'b00, cx};
      cys = {2'b00, cy};
      rs  = {{(CW-4){1'b0}}, ring_s};
      is  = {{(CW-4){idx_ff[3]}}, idx_ff};
      unique case (side_ff)
         SIDE_RIGHT: begin
            x = cxs + rs;
            y = cys + is;
         end
         SIDE_LEFT: begin
            x = cxs - rs;
            y = cys + is;
         end
         SIDE_TOP: begin
            x = cxs + is;
            y = cys + rs;
         end
         SIDE_BOTTOM: begin
            x = cxs + is;
            y = cys - rs;
         end
         default: begin
            x = cxs;
            y = cys;
         end
      endcase

      cand.x       = x;
      cand.y       = y;
      cand.ring    = ring_ff;
      // negative coordinates show up as the top bit
      cand.in_grid = !x[CW-1] && !y[CW-1] && (x[10:0] < grid_w) && (y[10:0] < grid_h);

      active_in = active_ff;
      ring_in   = ring_ff;
      side_in   = side_ff;
      idx_in    = idx_ff;
      if (start) begin
         active_in = 1'b1;
         ring_in   = 2'd1;
         side_in   = SIDE_RIGHT;
         idx_in    = -4'sd1;
      end else if (active_ff && advance) begin
         if (idx_ff != hi) begin
            idx_in = idx_ff + 4'sd1;
         end else begin
            unique case (side_ff)
               SIDE_RIGHT: begin
                  side_in = SIDE_LEFT;
                  idx_in  = -ring_s;
               end
               SIDE_LEFT: begin
                  side_in = SIDE_TOP;
                  idx_in  = 4'sd1 - ring_s;
               end
               SIDE_TOP: begin
                  side_in = SIDE_BOTTOM;
                  idx_in  = 4'sd1 - ring_s;
               end
               SIDE_BOTTOM: begin
                  if (ring_ff == rings) begin
                     active_in = 1'b0;
                  end else begin
                     ring_in = ring_ff + 2'd1;
                     side_in = SIDE_RIGHT;
                     idx_in  = -ring_s - 4'sd1;
                  end
               end
               default: begin
                  active_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      ring_ff <= ring_in;
      side_ff <= side_in;
      idx_ff  <= idx_in;
   end

   assign active = active_ff;

endmodule

// File: hw/rtl/grid_ring_neighbor_cells.sv
// Ring neighbor cell lister. A request beat gives a center cell and a radius in
// meters; the block answers with the center cell and then, ring by ring, every
// in-grid cell of the square rings around it (right column, left column, top
// row, bottom row), one result beat per cycle at best, the last beat marked.
// The ring count is (2*radius + cell_size) / (2*cell_size) + 1, capped at
// MAX_RING, found by a repeated-subtract unit. The ring walker then visits one
// candidate cell per cycle, holding while an in-grid cell waits for the result
// side, 4*r*(r+1) cells for r rings, whether or not they fall inside the grid.
// The request side stalls until the last beat of a request is loaded;
// configuration writes belong in idle time.
module grid_ring_neighbor_cells #(
   parameter int MAX_RING = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  grn_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output grn_pkg::rsp_type     rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [10:0]          csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [9:0]            cell_size_ff;
   logic [10:0]           grid_w_ff;
   logic [10:0]           grid_h_ff;
   grn_pkg::req_type      req_ff, req_in;
   grn_pkg::rsp_type      pend_ff, pend_in;
   grn_pkg::rsp_type      out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            rings_ff, rings_in;

   logic                  accept;
   logic                  out_free;
   logic                  load_out;
   logic                  walk_start;
   logic                  walk_advance;
   logic                  walk_active;
   grn_pkg::cand_type     cand;
   logic                  div_done;
   grn_pkg::div_res_type  div_res;
   logic [17:0]           numer;
   logic [10:0]           denom;
   logic [10:0]           w_eff;
   logic [10:0]           h_eff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign numer = {1'b0, req_data.radius, 1'b0} + {8'd0, cell_size_ff};
   assign denom = {cell_size_ff, 1'b0};
   assign w_eff = (grid_w_ff > grn_pkg::GRID_LIMIT) ? grn_pkg::GRID_LIMIT : grid_w_ff;
   assign h_eff = (grid_h_ff > grn_pkg::GRID_LIMIT) ? grn_pkg::GRID_LIMIT : grid_h_ff;

   grn_div #(
      .MAX_RING (MAX_RING)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .numer    (numer),
      .denom    (denom),
      .zero_div (cell_size_ff == 10'd0),
      .done     (div_done),
      .res      (div_res)
   );

   grn_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .advance (walk_advance),
      .cx      (req_ff.center_x),
      .cy      (req_ff.center_y),
      .rings   (rings_ff),
      .grid_w  (w_eff),
      .grid_h  (h_eff),
      .active  (walk_active),
      .cand    (cand)
   );

   // the center, then the newest in-grid cell, waits in pend until we know whether it is the last
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      rings_in     = rings_ff;
      load_out     = 1'b0;
      walk_start   = 1'b0;
      walk_advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               rings_in               = div_res.rings;
               pend_in.cell_x         = req_ff.center_x;
               pend_in.cell_y         = req_ff.center_y;
               pend_in.ring           = 2'd0;
               pend_in.radius_clamped = div_res.clamped;
               pend_in.last           = 1'b0;
               walk_start             = 1'b1;
               state_in               = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (walk_active) begin
               walk_advance = !cand.in_grid || out_free;
               if (cand.in_grid && out_free) begin
                  load_out       = 1'b1;
                  out_in         = pend_ff;
                  pend_in.cell_x = cand.x[9:0];
                  pend_in.cell_y = cand.y[9:0];
                  pend_in.ring   = cand.ring;
               end
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               load_out    = 1'b1;
               out_in      = pend_ff;
               out_in.last = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = load_out || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cell_size_ff <= 10'd64;
         grid_w_ff    <= 11'd16;
         grid_h_ff    <= 11'd16;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               grn_pkg::CSR_CELL_SIZE: cell_size_ff <= csr_wdata[9:0];
               grn_pkg::CSR_GRID_W:    grid_w_ff    <= csr_wdata;
               grn_pkg::CSR_GRID_H:    grid_h_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
      req_ff   <= req_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
      rings_ff <= rings_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: tb/sv/grid_ring_cell_checker.sv
module grid_ring_cell_checker #(
   parameter int MAX_RING = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  grn_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  grn_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [10:0]      csr_wdata,
   output int               n_fail,
   output int               n_pending,
   output int               n_beats
);

   // mirrored register file
   logic [9:0]  size_cfg;
   logic [10:0] w_cfg;
   logic [10:0] h_cfg;

   grn_pkg::rsp_type expected_cells[$];

   // cells of the request being listed
   grn_pkg::rsp_type ring_cells[49];
   int      n_ring_cells;
   bit      cur_clamped;
   int      cur_w;
   int      cur_h;

   grn_pkg::rsp_type want;
   bit      field_bad;

   function automatic void take_cell(int x, int y, int r);
      if (x >= 0 && x < cur_w && y >= 0 && y < cur_h) begin
         ring_cells[n_ring_cells] = '{cell_x: 10'(x), cell_y: 10'(y), ring: 2'(r),
                                      radius_clamped: cur_clamped, last: 1'b0};
         n_ring_cells++;
      end
   endfunction

   task automatic list_ring_cells(input grn_pkg::req_type rq);
      int cx;
      int cy;
      int nrings;
      cx = int'(rq.center_x);
      cy = int'(rq.center_y);
      cur_w = int'(w_cfg);
      cur_h = int'(h_cfg);
      if (cur_w > int'(grn_pkg::GRID_LIMIT)) cur_w = int'(grn_pkg::GRID_LIMIT);
      if (cur_h > int'(grn_pkg::GRID_LIMIT)) cur_h = int'(grn_pkg::GRID_LIMIT);
      // zero cell size counts as saturated
      if (size_cfg == '0) begin
         nrings = MAX_RING;
         cur_clamped = 1'b1;
      end else begin
         nrings = (2 * int'(rq.radius) + int'(size_cfg)) / (2 * int'(size_cfg)) + 1;
         cur_clamped = nrings > MAX_RING;
         if (cur_clamped) nrings = MAX_RING;
      end
      // center goes out even when it lies off the grid
      ring_cells[0] = '{cell_x: rq.center_x, cell_y: rq.center_y, ring: 2'd0,
                        radius_clamped: cur_clamped, last: 1'b0};
      n_ring_cells = 1;
      for (int r = 1; r <= nrings; r++) begin
         for (int i = -r; i <= r; i++) take_cell(cx + r, cy + i, r);
         for (int i = -r; i <= r; i++) take_cell(cx - r, cy + i, r);
         for (int i = -(r - 1); i <= r - 1; i++) take_cell(cx + i, cy + r, r);
         for (int i = -(r - 1); i <= r - 1; i++) take_cell(cx + i, cy - r, r);
      end
      ring_cells[n_ring_cells - 1].last = 1'b1;
      for (int i = 0; i < n_ring_cells; i++) expected_cells = {expected_cells, ring_cells[i]};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         size_cfg = 10'd64;
         w_cfg = 11'd16;
         h_cfg = 11'd16;
         expected_cells.delete();
         n_fail = 0;
         n_beats = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               grn_pkg::CSR_CELL_SIZE: size_cfg = csr_wdata[9:0];
               grn_pkg::CSR_GRID_W:    w_cfg = csr_wdata;
               grn_pkg::CSR_GRID_H:    h_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            n_beats++;
            if (expected_cells.size() == 0) begin
               if (n_fail < 10)
                  $display("unexpected beat %0d: x=%0d y=%0d ring=%0d clamp=%0b last=%0b",
                           n_beats, rsp_data.cell_x, rsp_data.cell_y, rsp_data.ring,
                           rsp_data.radius_clamped, rsp_data.last);
               n_fail++;
            end else begin
               want = expected_cells.pop_front();
               field_bad = rsp_data.cell_x !== want.cell_x
                  || rsp_data.cell_y !== want.cell_y
                  || rsp_data.ring !== want.ring
                  || rsp_data.radius_clamped !== want.radius_clamped
                  || rsp_data.last !== want.last;
               if (field_bad) begin
                  if (n_fail < 10)
                     $display({"beat %0d mismatch: expected x=%0d y=%0d ring=%0d clamp=%0b",
                               " last=%0b, got x=%0d y=%0d ring=%0d clamp=%0b last=%0b"},
                              n_beats, want.cell_x, want.cell_y, want.ring,
                              want.radius_clamped, want.last, rsp_data.cell_x,
                              rsp_data.cell_y, rsp_data.ring, rsp_data.radius_clamped,
                              rsp_data.last);
                  n_fail++;
               end
            end
         end
         if (req_valid && !req_stall) list_ring_cells(req_data);
      end
      n_pending <= expected_cells.size();
   end

endmodule

// File: tb/sv/grid_ring_neighbor_cells_tb.sv
module grid_ring_neighbor_cells_tb;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   grn_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   grn_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = grn_pkg::CSR_CELL_SIZE;
   logic [10:0]      csr_wdata = '0;

   int n_fail;
   int n_pending;
   int n_beats;
   int n_sent = 0;
   int n_settings = 0;

   // current setting, used to aim centers and radii
   int cur_size = 64;
   int eff_w = 16;
   int eff_h = 16;
   bit no_idle = 1'b0;

   grid_ring_neighbor_cells u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   grid_ring_cell_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 10);
   end

   task automatic send_query(input logic [9:0] cx, input logic [9:0] cy,
                             input logic [15:0] rad);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < 10) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{center_x: cx, center_y: cy, radius: rad};
      do @(posedge clock); while (req_stall);
      n_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (n_pending != 0);
      // settle before touching the registers
      repeat (64) @(posedge clock);
   endtask

   task automatic set_grid(input logic [9:0] cs, input logic [10:0] w, input logic [10:0] h);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= grn_pkg::CSR_CELL_SIZE;
      csr_wdata <= {1'b0, cs};
      @(posedge clock);
      csr_index <= grn_pkg::CSR_GRID_W;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= grn_pkg::CSR_GRID_H;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_size = int'(cs);
      eff_w = (int'(w) > 1024) ? 1024 : int'(w);
      eff_h = (int'(h) > 1024) ? 1024 : int'(h);
      n_settings++;
   endtask

   function automatic logic [9:0] pick_coord(int extent);
      int sel;
      sel = $urandom_range(0, 9);
      if (extent == 0 || sel < 2) return 10'($urandom());
      if (sel < 4) return 10'(($urandom_range(0, 1) != 0) ? extent - 1 - $urandom_range(0, 1)
                                                           : $urandom_range(0, 1));
      return 10'($urandom_range(0, extent - 1));
   endfunction

   function automatic logic [15:0] pick_radius();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 16'($urandom());
      if (sel == 1) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      // spans one, two, three rings and just past saturation
      return 16'($urandom_range(0, 3 * ((cur_size > 0) ? cur_size : 1)));
   endfunction

   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset setting: 64 m cells on a 16 x 16 grid
      send_query(10'd0, 10'd0, 16'd0);
      send_query(10'd15, 10'd15, 16'd0);
      send_query(10'd7, 10'd7, 16'd64);
      send_query(10'd7, 10'd7, 16'd160);
      send_query(10'd0, 10'd15, 16'd200);
      send_query(10'd1023, 10'd1023, 16'hFFFF);
      send_query(10'd20, 10'd3, 16'd100);
      // zero cell size saturates the ring count
      set_grid(10'd0, 11'd16, 11'd16);
      send_query(10'd5, 10'd5, 16'd0);
      send_query(10'd15, 10'd0, 16'd9);
      // empty grid gives the center alone
      set_grid(10'd64, 11'd0, 11'd0);
      send_query(10'd0, 10'd0, 16'd300);
      send_query(10'd1023, 10'd0, 16'd1);
      // oversized grid acts as 1024 cells
      set_grid(10'd1023, 11'd2047, 11'd2047);
      send_query(10'd1023, 10'd0, 16'hFFFF);
      send_query(10'd0, 10'd1023, 16'd0);
      send_query(10'd512, 10'd512, 16'd1023);
      send_query(10'd1022, 10'd1, 16'd2046);
      set_grid(10'd1, 11'd1, 11'd1);
      send_query(10'd0, 10'd0, 16'd1);
      send_query(10'd0, 10'd0, 16'd0);
      send_query(10'd1, 10'd0, 16'd5);
      set_grid(10'd5, 11'd1024, 11'd3);
      send_query(10'd1023, 10'd1, 16'd7);
      send_query(10'd0, 10'd2, 16'd2);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_grid(10'd1, 11'd1024, 11'd1024);
            1: set_grid(10'($urandom_range(2, 200)), 11'($urandom_range(1, 40)),
                        11'($urandom_range(1, 40)));
            2: set_grid(10'd1023, 11'd20, 11'd2047);
            3: set_grid(10'($urandom()), 11'($urandom()), 11'($urandom()));
            4: set_grid(10'd0, 11'($urandom_range(1, 30)), 11'($urandom_range(1, 30)));
            5: set_grid(10'($urandom_range(1, 1023)), 11'($urandom_range(1, 8)),
                        11'($urandom_range(1, 8)));
            6: set_grid(10'($urandom()), 11'd1024, 11'($urandom_range(1, 16)));
            default: set_grid(10'd32, 11'd16, 11'd16);
         endcase
         // one setting runs back to back with no gaps on either side
         if (ph == 3) no_idle <= 1'b1;
         for (int k = 0; k < 49; k++) begin
            if (ph == 1 && k == 24) wait_drained();
            send_query(pick_coord(eff_w), pick_coord(eff_h), pick_radius());
         end
         if (ph == 3) no_idle <= 1'b0;
      end

      wait_drained();
      $display("covered %0d requests over %0d register settings, %0d cell beats checked",
               n_sent, n_settings + 1, n_beats);
      if (n_fail == 0 && n_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
